[hw/rtl/bld_pkg.sv]
package bld_pkg;

	// default sizing
	localparam int unsigned CAPACITY_DEF   = 16;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	// operation codes
	typedef enum logic [3:0] {
		OP_PUSH_FRONT = 4'd0,
		OP_PUSH_BACK  = 4'd1,
		OP_POP_FRONT  = 4'd2,
		OP_POP_BACK   = 4'd3,
		OP_READ_FRONT = 4'd4,
		OP_READ_BACK  = 4'd5,
		OP_READ_AT    = 4'd6,
		OP_WRITE_AT   = 4'd7,
		OP_REMOVE_AT  = 4'd8,
		OP_FIND       = 4'd9,
		OP_CLEAR      = 4'd10
	} bld_op_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_RANGE = 2'd3
	} bld_status_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ALLOC,
		ST_WALK
	} bld_state_t;

	// command transaction
	typedef struct packed {
		logic [3:0]  operation;
		logic [31:0] value;
		logic [3:0]  position;
	} bld_cmd_t;

	// result transaction
	typedef struct packed {
		logic [31:0] data_out;
		logic [4:0]  found_position;
		logic [4:0]  length;
		logic [1:0]  status;
	} bld_rsp_t;

	// node store write enables
	typedef struct packed {
		logic data_we;
		logic next_we;
		logic prev_we;
	} bld_node_we_t;

endpackage

[hw/rtl/bounded_linked_deque_core.sv]
// sequencing: push, clear and any rejected command finish in ST_DECODE after the accepting edge
// (in ST_ALLOC when the slot comes off the free stack); done pulses for one cycle after the last step
// walked commands go on from ST_DECODE to ST_WALK, one node per step: 1 at the ends, position + 1 for
// positional access, up to length + 1 for find; one node per cycle through the node store port
// throughput: one command at a time, busy stays high until the command finishes
// reset: list empty and all slots free at once, no clearing pass; the receiver cannot stall
module bounded_linked_deque_core #(
	parameter int unsigned CAPACITY   = bld_pkg::CAPACITY_DEF,
	parameter int unsigned DATA_WIDTH = bld_pkg::DATA_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  bld_pkg::bld_cmd_t command,
	output logic              busy,
	output logic              done,
	output bld_pkg::bld_rsp_t result
);
	import bld_pkg::*;

	localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	// sequencer and list state
	bld_state_t            state_q, state_d;
	bld_op_t               op_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [3:0]            pos_q;
	logic [CW-1:0]         count_q, count_d;
	logic [CW-1:0]         hw_q, hw_d;
	logic [CW-1:0]         fs_cnt_q, fs_cnt_d;
	logic [SW-1:0]         head_q, head_d;
	logic [SW-1:0]         tail_q, tail_d;
	logic [CW-1:0]         idx_q, idx_d;
	logic [CW-1:0]         tgt_q, tgt_d;
	logic                  first_q, first_d;
	logic                  last_q, last_d;
	logic [SW-1:0]         cur_q;
	logic                  done_q;
	bld_rsp_t              result_q;

	// free slot stack
	logic [SW-1:0] fs_mem [CAPACITY];
	logic [SW-1:0] fs_rd_q;
	logic          fs_we;
	logic [SW-1:0] fs_waddr;
	logic [SW-1:0] fs_raddr;

	// node store port
	bld_node_we_t          node_we;
	logic [SW-1:0]         data_waddr, next_waddr, next_wdata, prev_waddr, prev_wdata;
	logic [DATA_WIDTH-1:0] data_wdata;
	logic [SW-1:0]         node_raddr;
	logic [DATA_WIDTH-1:0] data_rd;
	logic [SW-1:0]         next_rd, prev_rd;

	// control decisions
	logic          accept;
	logic          finish, go_alloc, go_walk, do_link, do_unlink;
	logic [SW-1:0] link_slot;
	logic [31:0]   rsp_data;
	logic [4:0]    rsp_found;
	bld_status_t   rsp_status;

	assign accept   = start && !busy;
	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign result   = result_q;
	assign fs_raddr = SW'(fs_cnt_q - 1'b1);

	bld_node_store #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_nodes (
		.clk        (clk),
		.node_we    (node_we),
		.data_waddr (data_waddr),
		.data_wdata (data_wdata),
		.next_waddr (next_waddr),
		.next_wdata (next_wdata),
		.prev_waddr (prev_waddr),
		.prev_wdata (prev_wdata),
		.raddr      (node_raddr),
		.data_rdata (data_rd),
		.next_rdata (next_rd),
		.prev_rdata (prev_rd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (go_alloc)     state_d = ST_ALLOC;
				else if (go_walk) state_d = ST_WALK;
				else              state_d = ST_IDLE;
			end
			ST_ALLOC: begin
				state_d = ST_IDLE;
			end
			ST_WALK: begin
				if (finish) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath control and register updates
	always_comb begin
		node_we    = '0;
		data_waddr = cur_q;
		data_wdata = val_q;
		next_waddr = cur_q;
		next_wdata = '0;
		prev_waddr = cur_q;
		prev_wdata = '0;
		node_raddr = head_q;
		fs_we      = 1'b0;
		fs_waddr   = SW'(fs_cnt_q);
		finish     = 1'b0;
		go_alloc   = 1'b0;
		go_walk    = 1'b0;
		do_link    = 1'b0;
		do_unlink  = 1'b0;
		rsp_data   = '0;
		rsp_found  = '0;
		rsp_status = STAT_OK;
		count_d    = count_q;
		hw_d       = hw_q;
		fs_cnt_d   = fs_cnt_q;
		head_d     = head_q;
		tail_d     = tail_q;
		idx_d      = idx_q;
		tgt_d      = tgt_q;
		first_d    = first_q;
		last_d     = last_q;
		link_slot  = (state_q == ST_ALLOC) ? fs_rd_q : SW'(hw_q);

		case (state_q)
			ST_DECODE: begin
				case (op_q)
					OP_PUSH_FRONT, OP_PUSH_BACK: begin
						if (count_q == CW'(CAPACITY)) begin
							finish     = 1'b1;
							rsp_status = STAT_FULL;
						end else if (fs_cnt_q != '0) begin
							go_alloc = 1'b1;
						end else begin
							// never used slot above the high-water mark
							do_link = 1'b1;
							hw_d    = hw_q + 1'b1;
							finish  = 1'b1;
						end
					end
					OP_POP_FRONT, OP_POP_BACK, OP_READ_FRONT, OP_READ_BACK: begin
						if (count_q == '0) begin
							finish     = 1'b1;
							rsp_status = STAT_EMPTY;
						end else begin
							// the end node is read directly, with no walk along the links
							go_walk = 1'b1;
							idx_d   = '0;
							tgt_d   = '0;
							if (op_q == OP_POP_FRONT || op_q == OP_READ_FRONT) begin
								node_raddr = head_q;
								first_d    = 1'b1;
								last_d     = (count_q == CW'(1));
							end else begin
								node_raddr = tail_q;
								first_d    = (count_q == CW'(1));
								last_d     = 1'b1;
							end
						end
					end
					OP_READ_AT, OP_WRITE_AT, OP_REMOVE_AT: begin
						if (32'(pos_q) >= 32'(count_q)) begin
							finish     = 1'b1;
							rsp_status = STAT_RANGE;
						end else begin
							go_walk    = 1'b1;
							node_raddr = head_q;
							idx_d      = '0;
							tgt_d      = CW'(pos_q);
							first_d    = (pos_q == '0);
							last_d     = (32'(pos_q) + 32'd1 == 32'(count_q));
						end
					end
					OP_FIND: begin
						if (count_q == '0) begin
							finish = 1'b1;
						end else begin
							go_walk    = 1'b1;
							node_raddr = head_q;
							idx_d      = '0;
						end
					end
					OP_CLEAR: begin
						count_d  = '0;
						hw_d     = '0;
						fs_cnt_d = '0;
						head_d   = '0;
						tail_d   = '0;
						finish   = 1'b1;
					end
					default: begin
						finish = 1'b1;
					end
				endcase
			end
			ST_ALLOC: begin
				// recycled slot from the top of the free stack
				do_link  = 1'b1;
				fs_cnt_d = fs_cnt_q - 1'b1;
				finish   = 1'b1;
			end
			ST_WALK: begin
				if (op_q == OP_FIND) begin
					if (idx_q == count_q) begin
						finish    = 1'b1;
						rsp_found = 5'(count_q);
					end else if (data_rd == val_q) begin
						finish    = 1'b1;
						rsp_found = 5'(idx_q);
					end else begin
						node_raddr = next_rd;
						idx_d      = idx_q + 1'b1;
					end
				end else if (idx_q == tgt_q) begin
					finish = 1'b1;
					case (op_q)
						OP_READ_FRONT, OP_READ_BACK, OP_READ_AT: begin
							rsp_data = 32'(data_rd);
						end
						OP_WRITE_AT: begin
							node_we.data_we = 1'b1;
							data_waddr      = cur_q;
							data_wdata      = val_q;
						end
						OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT: begin
							do_unlink = 1'b1;
							rsp_data  = 32'(data_rd);
						end
						default: begin
							rsp_data = '0;
						end
					endcase
				end else begin
					node_raddr = next_rd;
					idx_d      = idx_q + 1'b1;
				end
			end
			default: begin
				finish = 1'b0;
			end
		endcase

		// splice a new node in at one end
		if (do_link) begin
			node_we.data_we = 1'b1;
			node_we.next_we = 1'b1;
			node_we.prev_we = 1'b1;
			data_waddr      = link_slot;
			data_wdata      = val_q;
			if (op_q == OP_PUSH_FRONT) begin
				next_waddr = link_slot;
				next_wdata = head_q;
				prev_waddr = head_q;
				prev_wdata = link_slot;
				head_d     = link_slot;
			end else begin
				prev_waddr = link_slot;
				prev_wdata = tail_q;
				next_waddr = tail_q;
				next_wdata = link_slot;
				tail_d     = link_slot;
			end
			if (count_q == '0) begin
				head_d = link_slot;
				tail_d = link_slot;
			end
			count_d = count_q + 1'b1;
		end

		// unlink the current node and return its slot
		if (do_unlink) begin
			if (first_q) begin
				head_d = next_rd;
			end else begin
				node_we.next_we = 1'b1;
				next_waddr      = prev_rd;
				next_wdata      = next_rd;
			end
			if (last_q) begin
				tail_d = prev_rd;
			end else begin
				node_we.prev_we = 1'b1;
				prev_waddr      = next_rd;
				prev_wdata      = prev_rd;
			end
			fs_we    = 1'b1;
			fs_waddr = SW'(fs_cnt_q);
			fs_cnt_d = fs_cnt_q + 1'b1;
			count_d  = count_q - 1'b1;
			if (count_q == CW'(1)) begin
				head_d = '0;
				tail_d = '0;
			end
		end
	end

	// free stack storage
	always_ff @(posedge clk) begin
		if (fs_we) begin
			fs_mem[fs_waddr] <= cur_q;
		end
		fs_rd_q <= fs_mem[fs_raddr];
	end

	// command capture and node cursor
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= bld_op_t'(command.operation);
			val_q <= DATA_WIDTH'(command.value);
			pos_q <= command.position;
		end
		cur_q <= node_raddr;
		if (finish) begin
			result_q.data_out       <= rsp_data;
			result_q.found_position <= rsp_found;
			result_q.length         <= 5'(count_d);
			result_q.status         <= rsp_status;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			hw_q     <= '0;
			fs_cnt_q <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			idx_q    <= '0;
			tgt_q    <= '0;
			first_q  <= 1'b0;
			last_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			hw_q     <= hw_d;
			fs_cnt_q <= fs_cnt_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			idx_q    <= idx_d;
			tgt_q    <= tgt_d;
			first_q  <= first_d;
			last_q   <= last_d;
			done_q   <= finish;
		end
	end

	// length never exceeds the slot count
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	// every slot below the high-water mark is either live or on the free stack
	assert property (@(posedge clk) disable iff (!arst_n)
		hw_q == count_q + fs_cnt_q)
		else $error("slot accounting mismatch");

	// one result per transaction, never two in a row
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("back-to-back done pulses");

	// decode only follows an accepted command
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DECODE |-> $past(start && !busy))
		else $error("decode without accepted command");

	// a walk index never exceeds the list length
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> idx_q <= count_q)
		else $error("walk beyond list length");

endmodule

[hw/rtl/bld_node_store.sv]
module bld_node_store #(
	parameter int unsigned CAPACITY   = bld_pkg::CAPACITY_DEF,
	parameter int unsigned DATA_WIDTH = bld_pkg::DATA_WIDTH_DEF,
	localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                   clk,
	input  bld_pkg::bld_node_we_t  node_we,
	input  logic [SW-1:0]          data_waddr,
	input  logic [DATA_WIDTH-1:0]  data_wdata,
	input  logic [SW-1:0]          next_waddr,
	input  logic [SW-1:0]          next_wdata,
	input  logic [SW-1:0]          prev_waddr,
	input  logic [SW-1:0]          prev_wdata,
	input  logic [SW-1:0]          raddr,
	output logic [DATA_WIDTH-1:0]  data_rdata,
	output logic [SW-1:0]          next_rdata,
	output logic [SW-1:0]          prev_rdata
);
	import bld_pkg::*;

	logic [DATA_WIDTH-1:0] data_mem [CAPACITY];
	logic [SW-1:0]         next_mem [CAPACITY];
	logic [SW-1:0]         prev_mem [CAPACITY];

	// word store, registered read
	always_ff @(posedge clk) begin
		if (node_we.data_we) begin
			data_mem[data_waddr] <= data_wdata;
		end
		data_rdata <= data_mem[raddr];
	end

	// forward links
	always_ff @(posedge clk) begin
		if (node_we.next_we) begin
			next_mem[next_waddr] <= next_wdata;
		end
		next_rdata <= next_mem[raddr];
	end

	// backward links
	always_ff @(posedge clk) begin
		if (node_we.prev_we) begin
			prev_mem[prev_waddr] <= prev_wdata;
		end
		prev_rdata <= prev_mem[raddr];
	end

endmodule
